/* hdl/kprm_pkg.sv */
// Package for the key port response machine: widths, read constants and the key transition.
package kprm_pkg;

  localparam int KeyWidth     = 16;
  localparam int AddrWidth    = 9;
  localparam int DataWidth    = 8;
  localparam int InTdataWidth = 16;
  localparam int AnswerBit    = 15;
  localparam int QuestionBit  = 8;

  localparam logic [DataWidth-1:0] ReadOddByte   = 8'hFF;
  localparam logic [DataWidth-1:0] ReadEvenBase  = 8'hFE;

  // Bus access kinds carried on in_tuser.
  typedef enum logic {
    ACC_READ  = 1'b0,
    ACC_WRITE = 1'b1
  } access_t;

  // Next state of the key machine: each bit flips where its term is set.
  function automatic logic [KeyWidth-1:0] key_next(input logic [KeyWidth-1:0] s,
                                                   input logic a);
    logic [KeyWidth-1:0] z;
    logic [KeyWidth-1:0] t;
    logic na, k2, k3, k4, k5, k6, k7, k8;
    logic m, m15, m16, m17, m18, m19, m20, m21;
    z   = ~s;
    na  = ~a;
    k2  = s[0] & s[1];
    k3  = k2 & s[2];
    k4  = k3 & s[3];
    k5  = k4 & s[4];
    k6  = k5 & s[5];
    k7  = k6 & s[6];
    k8  = k7 & s[7];
    m   = k8 & na;
    m15 = m & s[8];
    m16 = m15 & s[9];
    m17 = m16 & s[10];
    m18 = m17 & s[11];
    m19 = m18 & s[12];
    m20 = m19 & s[13];
    m21 = m20 & s[14];
    t[0]  = (z[0] & na) | (s[0] & a);
    t[1]  = (z[1] & a) | (s[0] & z[1] & na) | (s[0] & s[1] & a);
    t[2]  = (s[0] & z[2] & a) | (s[1] & s[2] & a) | (k2 & z[2] & na);
    t[3]  = (s[0] & z[3] & na) | (s[1] & z[2] & s[3]) | (k3 & z[3] & na);
    t[4]  = (z[0] & s[2] & z[4]) | (z[1] & z[3] & s[4] & a) | (k4 & z[4] & na);
    t[5]  = (z[0] & z[2] & s[4] & z[5]) | (z[1] & s[3] & s[5] & a) | (k5 & z[5] & na);
    t[6]  = (z[4] & s[5] & z[6]) | (s[1] & z[2] & z[3] & s[6]) | (k6 & z[6] & na);
    t[7]  = (z[1] & s[4] & z[5] & z[7]) | (s[2] & s[3] & z[6] & s[7]) | (k7 & z[7] & na);
    t[8]  = (z[4] & s[5] & z[8]) | (z[3] & s[6] & z[7] & s[8]) | (m & z[8]);
    t[9]  = (z[6] & z[8] & s[9]) | (z[5] & s[7] & z[9]) | (m15 & z[9]);
    t[10] = (z[5] & s[10]) | (z[7] & z[9] & z[10]) | (m16 & z[10]);
    t[11] = (z[8] & s[9] & s[11]) | (s[5] & z[7] & s[10] & z[11]) | (m17 & z[11]);
    t[12] = (s[7] & z[8] & z[12]) | (s[9] & z[10] & s[11] & s[12]) | (m18 & z[12]);
    t[13] = (z[9] & z[12] & z[13]) | (s[10] & z[11] & s[13]) | (m19 & z[13]);
    t[14] = (z[10] & s[11] & z[14]) | (z[9] & s[12] & z[13] & s[14]) | (m20 & z[14]);
    t[15] = (z[1] & s[15]) | (s[2] & a & z[15])
          | (s[6] & na & z[9] & z[11] & s[15])
          | (z[3] & s[6] & a & s[10] & z[14] & s[15])
          | (m21 & z[15]);
    return s ^ t;
  endfunction

endpackage

/* hdl/key_port_response_machine_core.sv */
// Top level of the key port response machine: key register, response logic and output skid.
// A read response is registered into the output register, or into the skid entry while that register is held.
// Throughput: one request per cycle while the skid entry is empty; writes are absorbed and produce no response.
// The output register plus one skid entry let a request enter while a response waits.
// Reset (rst_n low, synchronous) clears the key register and empties both output entries.
module key_port_response_machine_core
  import kprm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [InTdataWidth-1:0] in_tdata,  // [8:0] address_low_bits, [15:9] zero
  input  logic                    in_tuser,  // [0] action (0 read, 1 write)
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [DataWidth-1:0]    out_tdata  // [7:0] read_data
);

  logic [KeyWidth-1:0]  key_r, key_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DataWidth-1:0] out_data_r, out_data_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  logic [DataWidth-1:0] skid_data_r, skid_data_nxt;

  logic                 in_fire;
  logic                 out_fire;
  logic                 produce;
  logic [AddrWidth-1:0] addr;
  logic                 odd_byte;
  logic [DataWidth-1:0] resp_data;

  // The skid entry is only ever filled while the output register is held, so
  // a request can enter whenever the skid entry is empty.
  assign in_tready = ~skid_valid_r;
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_valid_r & out_tready;

  assign addr     = in_tdata[AddrWidth-1:0];
  assign odd_byte = addr[0];
  // Every read gives a response; writes leave the key alone and give none.
  assign produce  = in_fire & (access_t'(in_tuser) == ACC_READ);

  always_comb begin
    // The answer bit is sampled before the key is clocked.
    resp_data = odd_byte ? ReadOddByte
                         : (ReadEvenBase | DataWidth'(key_r[AnswerBit]));
    key_nxt = key_r;
    if (produce && !odd_byte) begin
      key_nxt = key_next(key_r, addr[QuestionBit]);
    end
  end

  // Output register with one skid entry behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (produce) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = resp_data;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (produce) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = resp_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      key_r        <= key_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* hdl/kprm_checker.sv */
// Port-level checker for the key port response machine and its bind.
module kprm_checker
  import kprm_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_tvalid,
  input logic                    in_tready,
  input logic [InTdataWidth-1:0] in_tdata,
  input logic                    in_tuser,
  input logic                    out_tvalid,
  input logic                    out_tready,
  input logic [DataWidth-1:0]    out_tdata
);

  // A response that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("response changed while stalled");

  // Every response byte has its upper seven bits set.
  a_resp_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:1] == 7'h7F)
    else $error("response byte malformed");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("response present after reset");

  // A write into an empty block produces nothing.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && in_tvalid && in_tready && in_tuser |=> !out_tvalid)
    else $error("write produced a response");

  // An odd read into an empty block answers 0xFF in the next cycle.
  a_odd_read: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && in_tvalid && in_tready && !in_tuser && in_tdata[0]
      |=> out_tvalid && out_tdata == ReadOddByte)
    else $error("odd read answered wrongly");

endmodule

bind key_port_response_machine_core kprm_checker u_kprm_checker (.*);
